FILE: src/assert_macros.svh
// assertion macros used by the bank mapper rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BMIT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define BMIT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/bmit_pkg.sv
// shared types and constants for the bank mapper with irq counter and tones
// no dependencies
package bmit_pkg;

    localparam int CHAR_SLOTS      = 8;
    localparam int SOUND_REG_COUNT = 16;
    localparam int TONE_CHANNELS   = 3;
    localparam int TONE_SLOTS      = 3;
    localparam int PRESCALE        = 16;
    localparam int PRESC_W         = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
    localparam int CHAR_AW         = $clog2(CHAR_SLOTS);
    localparam int SOUND_AW        = $clog2(SOUND_REG_COUNT);

    // opcodes
    localparam logic [2:0] OP_CPU_RD = 3'd0;
    localparam logic [2:0] OP_CPU_WR = 3'd1;
    localparam logic [2:0] OP_PPU_RD = 3'd2;
    localparam logic [2:0] OP_PPU_WR = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_ACK    = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [1:0] CFG_CHR_COUNT = 2'd1;

    // mapper commands
    localparam logic [3:0] CMD_PRG0   = 4'h8;
    localparam logic [3:0] CMD_PRG1   = 4'h9;
    localparam logic [3:0] CMD_PRG2   = 4'hA;
    localparam logic [3:0] CMD_PRG3   = 4'hB;
    localparam logic [3:0] CMD_MIRROR = 4'hC;
    localparam logic [3:0] CMD_IRQCTL = 4'hD;
    localparam logic [3:0] CMD_CNT_LO = 4'hE;
    localparam logic [3:0] CMD_CNT_HI = 4'hF;

    // sound register numbers
    localparam logic [SOUND_AW-1:0] SND_MIXER   = SOUND_AW'(7);
    localparam logic [SOUND_AW-1:0] SND_VOLUME0 = SOUND_AW'(8);

    // remainder unit request
    typedef struct packed {
        logic        start;
        logic [7:0]  dividend;
        logic [10:0] divisor;
    } t_div_req;

endpackage

FILE: src/bmit_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module bmit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bmit_div.sv
// bit-serial remainder unit: 8-bit dividend modulo an 11-bit divisor
// depends on bmit_pkg
module bmit_div import bmit_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [10:0] o_rem
);

    logic        r_busy;
    logic [2:0]  r_cnt;
    logic [7:0]  r_dvd;
    logic [10:0] r_dvs;
    logic [10:0] r_rem;
    logic        r_done;
    logic [11:0] trial;
    logic [11:0] diff;

    // one restoring step per cycle
    assign trial = {r_rem, r_dvd[7]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[6:0], 1'b0};
                r_rem <= (trial >= {1'b0, r_dvs}) ? diff[10:0] : trial[10:0];
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: src/bank_mapper_irq_tone_unit.sv
// Cartridge bank mapper with a wrapping 16-bit irq down-counter and three
// square-tone channels behind a divide-by-PRESCALE prescaler. One word is taken
// at a time. Register writes, unclaimed accesses, irq acknowledges, character
// RAM accesses and reads of the fixed top window pass only the done state on
// their way to the output register; a mapped program read first passes the
// 8-step serial remainder unit that reduces the bank number modulo the bank
// count, and a character ROM read first reads the character bank memory and
// then passes that unit. A tick steps through the single read port of the
// sound register memory, which is read once for the mixer and three times per
// channel. The input is stalled while a word is in work; a finished word waits in the output register.
// depends on bmit_pkg, bmit_ram, bmit_div and assert_macros.svh
`include "assert_macros.svh"

module bank_mapper_irq_tone_unit import bmit_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_opcode,
    input  logic [15:0]        i_address,
    input  logic [7:0]         i_write_data,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_handled,
    output logic [21:0]        o_mapped_address,
    output logic               o_irq_line,
    output logic [1:0]         o_mirroring,
    output logic               o_low_window_ram_on,
    output logic signed [4:0]  o_tone_a_level,
    output logic signed [4:0]  o_tone_b_level,
    output logic signed [4:0]  o_tone_c_level
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHR  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_TONE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [1:0] SUB_LO  = 2'd0;
    localparam logic [1:0] SUB_HI  = 2'd1;
    localparam logic [1:0] SUB_VOL = 2'd2;
    localparam logic [1:0] SUB_MIX = 2'd3;

    localparam logic [1:0] LAST_CH = 2'(TONE_CHANNELS - 1);

    logic [2:0]  r_state, n_state;
    logic [8:0]  r_prg_count;
    logic [10:0] r_chr_count;
    logic [3:0]  r_cmd;
    logic [7:0]  r_prg [4];
    logic [1:0]  r_mirror;
    logic        r_wsel, r_wen;
    logic        r_irq_en, r_cnt_en, r_irq_pend;
    logic [15:0] r_irq_cnt;
    logic [SOUND_AW-1:0] r_snd_sel;
    logic [PRESC_W-1:0]  r_presc;
    logic        r_wrap;
    logic [CHAR_SLOTS-1:0]      r_chr_vld;
    logic [SOUND_REG_COUNT-1:0] r_snd_vld;

    logic        r_claim;
    logic [21:0] r_where;
    logic [12:0] r_off;
    logic        r_is_chr;
    logic [CHAR_AW-1:0] r_chr_slot;
    logic        r_chr_rvld;

    // tone sequencer
    logic        r_iact;
    logic [1:0]  r_ich, r_isub;
    logic        r_dact;
    logic [1:0]  r_dch, r_dsub;
    logic        r_snd_rvld;
    logic [2:0]  r_mix;
    logic [7:0]  r_len_lo;
    logic [11:0] r_tcnt [TONE_SLOTS];
    logic        r_tph  [TONE_SLOTS];
    logic signed [4:0] r_smp [TONE_SLOTS];

    // output register
    logic        r_out_valid;
    logic        r_o_handled;
    logic [21:0] r_o_addr;
    logic        r_o_irq;
    logic [1:0]  r_o_mirror;
    logic        r_o_wen;
    logic signed [4:0] r_o_lvl [TONE_SLOTS];

    logic        in_acc;
    logic        out_free;
    logic [7:0]  chr_q, snd_q, snd_d;
    logic        chr_we, snd_we;
    logic [SOUND_AW-1:0] snd_raddr;
    logic [8:0]  prg_last;
    logic        div_done;
    logic [10:0] div_rem;
    t_div_req    div_req;
    logic [7:0]  prg_bank;
    logic        prg_div;
    logic [11:0] len;
    logic [3:0]  vol;
    logic        div_src_ok;
    logic        done_go;
    logic        tick_acc;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign prg_last = (r_prg_count == 9'd0) ? 9'd0 : r_prg_count - 9'd1;

    // cpu read window decode
    always_comb begin
        prg_div  = 1'b0;
        prg_bank = r_prg[0];
        if (i_address[15:13] == 3'b011) begin
            prg_div = !r_wsel;
        end else if (i_address[15:13] == 3'b100) begin
            prg_div  = 1'b1;
            prg_bank = r_prg[1];
        end else if (i_address[15:13] == 3'b101) begin
            prg_div  = 1'b1;
            prg_bank = r_prg[2];
        end else if (i_address[15:13] == 3'b110) begin
            prg_div  = 1'b1;
            prg_bank = r_prg[3];
        end
    end

    // remainder unit requests
    always_comb begin
        div_req = '0;
        if (r_state == S_IDLE && in_acc && i_opcode == OP_CPU_RD && prg_div) begin
            div_req.start    = 1'b1;
            div_req.dividend = prg_bank;
            div_req.divisor  = (r_prg_count == 9'd0) ? 11'd1 : {2'b00, r_prg_count};
        end else if (r_state == S_CHR) begin
            div_req.start    = 1'b1;
            div_req.dividend = r_chr_rvld ? chr_q : 8'(r_chr_slot);
            div_req.divisor  = r_chr_count;
        end
    end

    bmit_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    // character bank memory, written through the parameter register
    assign chr_we = (r_state == S_IDLE) && in_acc && i_opcode == OP_CPU_WR
                    && i_address[15:13] == 3'b101 && !r_cmd[3];

    bmit_ram #(.WIDTH(8), .DEPTH(CHAR_SLOTS)) u_chr_ram (
        .i_clk   (i_clk),
        .i_we    (chr_we),
        .i_waddr (r_cmd[CHAR_AW-1:0]),
        .i_wdata (i_write_data),
        .i_raddr (i_address[10 +: CHAR_AW]),
        .o_rdata (chr_q)
    );

    // sound register memory
    assign snd_we = (r_state == S_IDLE) && in_acc && i_opcode == OP_CPU_WR
                    && i_address[15:13] == 3'b111;

    always_comb begin
        case (r_isub)
            SUB_LO:  snd_raddr = SOUND_AW'({r_ich, 1'b0});
            SUB_HI:  snd_raddr = SOUND_AW'({r_ich, 1'b1});
            SUB_VOL: snd_raddr = SND_VOLUME0 + SOUND_AW'(r_ich);
            default: snd_raddr = SND_MIXER;
        endcase
    end

    bmit_ram #(.WIDTH(8), .DEPTH(SOUND_REG_COUNT)) u_snd_ram (
        .i_clk   (i_clk),
        .i_we    (snd_we),
        .i_waddr (r_snd_sel),
        .i_wdata (i_write_data),
        .i_raddr (snd_raddr),
        .o_rdata (snd_q)
    );

    assign snd_d = r_snd_rvld ? snd_q : 8'd0;
    assign len   = {snd_d[3:0], r_len_lo};
    assign vol   = snd_d[3:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == OP_CPU_RD && prg_div) begin
                        n_state = S_DIV;
                    end else if (i_opcode == OP_PPU_RD && i_address[15:13] == 3'b000
                                 && r_chr_count != 11'd0) begin
                        n_state = S_CHR;
                    end else if (i_opcode == OP_TICK) begin
                        n_state = S_TONE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CHR:  n_state = S_DIV;
            S_DIV:  n_state = div_done ? S_DONE : S_DIV;
            S_TONE: begin
                if (r_dact && r_dsub == SUB_VOL && r_dch == LAST_CH) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and mapper state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prg_count <= 9'd2;
            r_chr_count <= 11'd8;
            r_cmd       <= '0;
            r_prg[0]    <= 8'd0;
            r_prg[1]    <= 8'd1;
            r_prg[2]    <= 8'd2;
            r_prg[3]    <= 8'hFF;
            r_mirror    <= '0;
            r_wsel      <= 1'b0;
            r_wen       <= 1'b0;
            r_irq_en    <= 1'b0;
            r_cnt_en    <= 1'b0;
            r_irq_pend  <= 1'b0;
            r_irq_cnt   <= '0;
            r_snd_sel   <= '0;
            r_presc     <= '0;
            r_chr_vld   <= '0;
            r_snd_vld   <= '0;
            r_iact      <= 1'b0;
            r_dact      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < TONE_SLOTS; c++) begin
                r_tcnt[c] <= '0;
                r_tph[c]  <= 1'b0;
                r_smp[c]  <= '0;
            end
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PRG_COUNT) begin
                    r_prg_count <= i_cfg_data[8:0];
                end else if (i_cfg_index == CFG_CHR_COUNT) begin
                    r_chr_count <= i_cfg_data;
                end
            end

            if (chr_we) begin
                r_chr_vld[r_cmd[CHAR_AW-1:0]] <= 1'b1;
            end
            if (snd_we) begin
                r_snd_vld[r_snd_sel] <= 1'b1;
            end

            // word decode on accept
            if (r_state == S_IDLE && in_acc) begin
                r_claim  <= 1'b0;
                r_where  <= '0;
                r_off    <= i_address[12:0];
                r_is_chr <= (i_opcode == OP_PPU_RD);
                r_chr_slot <= i_address[10 +: CHAR_AW];
                r_chr_rvld <= r_chr_vld[i_address[10 +: CHAR_AW]];
                case (i_opcode)
                    OP_CPU_RD: begin
                        if (i_address[15:13] == 3'b111) begin
                            r_claim <= 1'b1;
                            r_where <= {prg_last, i_address[12:0]};
                        end else begin
                            r_claim <= prg_div;
                        end
                    end
                    OP_CPU_WR: begin
                        r_claim <= i_address[15];
                        if (i_address[15:13] == 3'b111) begin
                            // sound register write, handled by the memory port
                        end else if (i_address[15:13] == 3'b110) begin
                            r_snd_sel <= i_write_data[SOUND_AW-1:0];
                        end else if (i_address[15:13] == 3'b101) begin
                            case (r_cmd)
                                CMD_PRG0: begin
                                    r_prg[0] <= {2'b00, i_write_data[5:0]};
                                    r_wsel   <= i_write_data[6];
                                    r_wen    <= i_write_data[7];
                                end
                                CMD_PRG1:   r_prg[1] <= {2'b00, i_write_data[5:0]};
                                CMD_PRG2:   r_prg[2] <= {2'b00, i_write_data[5:0]};
                                CMD_PRG3:   r_prg[3] <= {2'b00, i_write_data[5:0]};
                                CMD_MIRROR: r_mirror <= i_write_data[1:0];
                                CMD_IRQCTL: begin
                                    r_irq_en   <= i_write_data[0];
                                    r_cnt_en   <= i_write_data[7];
                                    r_irq_pend <= 1'b0;
                                end
                                CMD_CNT_LO: r_irq_cnt[7:0]  <= i_write_data;
                                CMD_CNT_HI: r_irq_cnt[15:8] <= i_write_data;
                                default: ;
                            endcase
                        end else if (i_address[15:13] == 3'b100) begin
                            r_cmd <= i_write_data[3:0];
                        end
                    end
                    OP_PPU_RD: begin
                        if (i_address[15:13] == 3'b000) begin
                            r_claim <= 1'b1;
                            r_where <= {9'd0, i_address[12:0]};
                        end
                    end
                    OP_PPU_WR: begin
                        if (i_address[15:13] == 3'b000 && r_chr_count == 11'd0) begin
                            r_claim <= 1'b1;
                            r_where <= {9'd0, i_address[12:0]};
                        end
                    end
                    OP_TICK: begin
                        r_wrap  <= (r_presc == PRESC_W'(PRESCALE - 1));
                        r_presc <= (r_presc == PRESC_W'(PRESCALE - 1))
                                   ? '0 : r_presc + PRESC_W'(1);
                        if (r_cnt_en) begin
                            r_irq_cnt <= r_irq_cnt - 16'd1;
                            if (r_irq_cnt == 16'd0 && r_irq_en) begin
                                r_irq_pend <= 1'b1;
                            end
                        end
                        r_iact <= 1'b1;
                        r_ich  <= 2'd0;
                        r_isub <= SUB_MIX;
                    end
                    OP_ACK:  r_irq_pend <= 1'b0;
                    default: ;
                endcase
            end

            // remainder result into the mapped address
            if (r_state == S_DIV && div_done) begin
                if (r_is_chr) begin
                    r_where <= {1'b0, div_rem, r_off[9:0]};
                end else begin
                    r_where <= {div_rem[8:0], r_off};
                end
            end

            // tone read issue side
            r_dact     <= r_iact;
            r_dch      <= r_ich;
            r_dsub     <= r_isub;
            r_snd_rvld <= r_snd_vld[snd_raddr];
            if (r_iact) begin
                case (r_isub)
                    SUB_MIX: r_isub <= SUB_LO;
                    SUB_LO:  r_isub <= SUB_HI;
                    SUB_HI:  r_isub <= SUB_VOL;
                    default: begin
                        r_isub <= SUB_LO;
                        r_ich  <= r_ich + 2'd1;
                        if (r_ich == LAST_CH) begin
                            r_iact <= 1'b0;
                        end
                    end
                endcase
            end

            // tone read data side
            if (r_dact) begin
                case (r_dsub)
                    SUB_MIX: r_mix    <= snd_d[2:0];
                    SUB_LO:  r_len_lo <= snd_d;
                    SUB_HI: begin
                        if (r_wrap) begin
                            if (r_tcnt[r_dch] == 12'd0) begin
                                r_tcnt[r_dch] <= (len == 12'd0) ? 12'd1 : len;
                                r_tph[r_dch]  <= !r_tph[r_dch];
                            end else begin
                                r_tcnt[r_dch] <= r_tcnt[r_dch] - 12'd1;
                            end
                        end
                    end
                    default: begin
                        if (r_mix[r_dch] || vol == 4'd0) begin
                            r_smp[r_dch] <= '0;
                        end else if (r_tph[r_dch]) begin
                            r_smp[r_dch] <= $signed({1'b0, vol});
                        end else begin
                            r_smp[r_dch] <= -$signed({1'b0, vol});
                        end
                    end
                endcase
            end

            // output register
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_o_handled <= r_claim;
                r_o_addr    <= r_where;
                r_o_irq     <= r_irq_pend;
                r_o_mirror  <= r_mirror;
                r_o_wen     <= r_wen;
                for (int c = 0; c < TONE_SLOTS; c++) begin
                    r_o_lvl[c] <= (c < TONE_CHANNELS) ? r_smp[c] : 5'sd0;
                end
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_handled           = r_o_handled;
    assign o_mapped_address    = r_o_addr;
    assign o_irq_line          = r_o_irq;
    assign o_mirroring         = r_o_mirror;
    assign o_low_window_ram_on = r_o_wen;
    assign o_tone_a_level      = r_o_lvl[0];
    assign o_tone_b_level      = r_o_lvl[1];
    assign o_tone_c_level      = r_o_lvl[2];

    // check terms
    assign div_src_ok = (r_state == S_IDLE) || (r_state == S_CHR);
    assign done_go    = (r_state == S_DONE) && out_free;
    assign tick_acc   = in_acc && (i_opcode == OP_TICK);

    // checks
    `BMIT_ASSERT_IMP(a_div_from_idle_or_chr, i_clk, i_rst_n, div_req.start, div_src_ok)
    `BMIT_ASSERT_NXT(a_done_fills_output, i_clk, i_rst_n, done_go, r_out_valid)
    `BMIT_ASSERT_NXT(a_irq_only_on_tick, i_clk, i_rst_n, !r_irq_pend && !tick_acc, !r_irq_pend)

endmodule

FILE: tb/tb_top.sv
// testbench for the bank mapper with irq counter and tone channels
// depends on bmit_pkg and bank_mapper_irq_tone_unit; scoreboard class inside
`timescale 1ns / 100ps

module tb_top;
    import bmit_pkg::*;

    // result word as compared
    typedef struct packed {
        logic        handled;
        logic [21:0] maddr;
        logic        irq;
        logic [1:0]  mirror;
        logic        wram_on;
        logic [4:0]  lvl_a;
        logic [4:0]  lvl_b;
        logic [4:0]  lvl_c;
    } t_result;

    // mapper predictor plus queue of pending results
    class mapper_scoreboard;
        int unsigned prg_count, chr_count;
        logic [3:0]  cmd_sel;
        logic [7:0]  chr_bank [8];
        logic [7:0]  prg_bank [4];
        logic [1:0]  mirror;
        logic        wram_sel, wram_en, irq_en, cnt_en, irq_pend;
        logic [15:0] irq_cnt;
        logic [3:0]  snd_sel;
        logic [7:0]  snd_reg [16];
        int unsigned presc;
        logic [11:0] tone_cnt [3];
        logic        phase [3];
        logic [4:0]  level [3];
        t_result     pending [$];
        int          mismatches;
        int          checked;

        function new();
            prg_count = 2;
            chr_count = 8;
            cmd_sel = 0;
            for (int i = 0; i < 8; i++) chr_bank[i] = 8'(i);
            prg_bank[0] = 0; prg_bank[1] = 1; prg_bank[2] = 2; prg_bank[3] = 8'hFF;
            mirror = 0; wram_sel = 0; wram_en = 0;
            irq_en = 0; cnt_en = 0; irq_pend = 0; irq_cnt = 0;
            snd_sel = 0;
            for (int i = 0; i < 16; i++) snd_reg[i] = 0;
            presc = 0;
            for (int i = 0; i < 3; i++) begin
                tone_cnt[i] = 0; phase[i] = 0; level[i] = 0;
            end
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [10:0] val);
            if (idx == CFG_PRG_COUNT) prg_count = val[8:0];
            else if (idx == CFG_CHR_COUNT) chr_count = val;
        endfunction

        function logic [21:0] prg_addr(int unsigned bank, logic [15:0] a);
            int unsigned total;
            total = (prg_count == 0) ? 1 : prg_count;
            return 22'((bank % total) * 32'h2000 + (a & 16'h1FFF));
        endfunction

        function void param_write(logic [7:0] v);
            if (cmd_sel < 4'h8) begin
                chr_bank[cmd_sel[2:0]] = v;
            end else begin
                case (cmd_sel)
                    CMD_PRG0: begin
                        prg_bank[0] = v & 8'h3F;
                        wram_sel = v[6];
                        wram_en = v[7];
                    end
                    CMD_PRG1: prg_bank[1] = v & 8'h3F;
                    CMD_PRG2: prg_bank[2] = v & 8'h3F;
                    CMD_PRG3: prg_bank[3] = v & 8'h3F;
                    CMD_MIRROR: mirror = v[1:0];
                    CMD_IRQCTL: begin
                        irq_en = v[0];
                        cnt_en = v[7];
                        irq_pend = 0;
                    end
                    CMD_CNT_LO: irq_cnt[7:0] = v;
                    default: irq_cnt[15:8] = v;
                endcase
            end
        endfunction

        function void do_tick();
            logic [11:0] period;
            logic [3:0]  vol;
            presc++;
            if (presc >= PRESCALE) begin
                presc = 0;
                for (int ch = 0; ch < 3; ch++) begin
                    period = {snd_reg[ch*2+1][3:0], snd_reg[ch*2]};
                    if (period == 0) period = 1;
                    if (tone_cnt[ch] == 0) begin
                        tone_cnt[ch] = period;
                        phase[ch] = ~phase[ch];
                    end else begin
                        tone_cnt[ch]--;
                    end
                end
            end
            for (int ch = 0; ch < 3; ch++) begin
                vol = snd_reg[8+ch][3:0];
                if (snd_reg[7][ch] || vol == 0) level[ch] = 0;
                else level[ch] = phase[ch] ? {1'b0, vol} : -{1'b0, vol};
            end
            if (cnt_en) begin
                if (irq_cnt == 0 && irq_en) irq_pend = 1;
                irq_cnt = irq_cnt - 1;
            end
        endfunction

        // accepted input word: update state and queue the expected result
        function void note_word(logic [2:0] op, logic [15:0] a, logic [7:0] v);
            t_result r;
            r = '0;
            case (op)
                OP_CPU_RD: begin
                    if (a >= 16'h6000 && a < 16'h8000) begin
                        if (!wram_sel) begin
                            r.handled = 1; r.maddr = prg_addr(prg_bank[0], a);
                        end
                    end else if (a >= 16'h8000 && a < 16'hA000) begin
                        r.handled = 1; r.maddr = prg_addr(prg_bank[1], a);
                    end else if (a >= 16'hA000 && a < 16'hC000) begin
                        r.handled = 1; r.maddr = prg_addr(prg_bank[2], a);
                    end else if (a >= 16'hC000 && a < 16'hE000) begin
                        r.handled = 1; r.maddr = prg_addr(prg_bank[3], a);
                    end else if (a >= 16'hE000) begin
                        r.handled = 1;
                        r.maddr = prg_addr(((prg_count == 0) ? 1 : prg_count) - 1, a);
                    end
                end
                OP_CPU_WR: begin
                    if (a >= 16'hE000) begin
                        snd_reg[snd_sel] = v; r.handled = 1;
                    end else if (a >= 16'hC000) begin
                        snd_sel = v[3:0]; r.handled = 1;
                    end else if (a >= 16'hA000) begin
                        param_write(v); r.handled = 1;
                    end else if (a >= 16'h8000) begin
                        cmd_sel = v[3:0]; r.handled = 1;
                    end
                end
                OP_PPU_RD: begin
                    if (a < 16'h2000) begin
                        r.handled = 1;
                        if (chr_count == 0) r.maddr = 22'(a & 16'h1FFF);
                        else r.maddr = 22'((chr_bank[a[12:10]] % chr_count) * 32'h400
                                           + (a & 16'h03FF));
                    end
                end
                OP_PPU_WR: begin
                    if (a < 16'h2000 && chr_count == 0) begin
                        r.handled = 1; r.maddr = 22'(a & 16'h1FFF);
                    end
                end
                OP_TICK: do_tick();
                OP_ACK: irq_pend = 0;
                default: ;
            endcase
            r.irq = irq_pend;
            r.mirror = mirror;
            r.wram_on = wram_en;
            r.lvl_a = level[0];
            r.lvl_b = level[1];
            r.lvl_c = level[2];
            pending.push_back(r);
        endfunction

        function void check_word(t_result got);
            t_result want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("mismatch: hnd %b/%b addr %h/%h irq %b/%b mir %0d/%0d ram %b/%b ",
                        want.handled, got.handled, want.maddr, got.maddr, want.irq, got.irq,
                        want.mirror, got.mirror, want.wram_on, got.wram_on);
                    $display("lv %0d %0d %0d / %0d %0d %0d",
                        $signed(want.lvl_a), $signed(want.lvl_b), $signed(want.lvl_c),
                        $signed(got.lvl_a), $signed(got.lvl_b), $signed(got.lvl_c));
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        out_valid;
    logic        out_stall;
    logic        handled;
    logic [21:0] mapped_address;
    logic        irq_line;
    logic [1:0]  mirroring;
    logic        ram_on;
    logic signed [4:0] lvl_a, lvl_b, lvl_c;

    mapper_scoreboard sb;
    bit no_idle;
    int sent;

    bank_mapper_irq_tone_unit i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_opcode           (opcode),
        .i_address          (address),
        .i_write_data       (write_data),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_handled          (handled),
        .o_mapped_address   (mapped_address),
        .o_irq_line         (irq_line),
        .o_mirroring        (mirroring),
        .o_low_window_ram_on(ram_on),
        .o_tone_a_level     (lvl_a),
        .o_tone_b_level     (lvl_b),
        .o_tone_c_level     (lvl_c)
    );

    initial clk = 0;
    always #4 clk = ~clk;

    // result side: random stall bursts, check at the rising edge
    initial begin
        int burst;
        out_stall = 0;
        forever begin
            @(negedge clk);
            if (!no_idle && burst == 0 && $urandom_range(0, 9) == 0)
                burst = $urandom_range(1, 6);
            if (burst > 0) begin
                out_stall <= 1;
                burst--;
            end else begin
                out_stall <= 0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word({handled, mapped_address, irq_line, mirroring, ram_on,
                           lvl_a, lvl_b, lvl_c});
    end

    // send one word, then maybe a gap
    task automatic send_word(logic [2:0] op, logic [15:0] a, logic [7:0] v);
        opcode <= op;
        address <= a;
        write_data <= v;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        sb.note_word(op, a, v);
        sent++;
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        drain();
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic mapper_write(logic [3:0] cmd, logic [7:0] v);
        send_word(OP_CPU_WR, 16'h8000 | 16'($urandom_range(0, 16'h1FFF)), {4'($urandom), cmd});
        send_word(OP_CPU_WR, 16'hA000 | 16'($urandom_range(0, 16'h1FFF)), v);
    endtask

    task automatic sound_write(logic [3:0] idx, logic [7:0] v);
        send_word(OP_CPU_WR, 16'hC000 | 16'($urandom_range(0, 16'h1FFF)), {4'($urandom), idx});
        send_word(OP_CPU_WR, 16'hE000 | 16'($urandom_range(0, 16'h1FFF)), v);
    endtask

    // mostly well-formed register pairs, reads and ticks
    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) mapper_write(4'($urandom), 8'($urandom));
        else if (pick < 25) sound_write(4'($urandom), 8'($urandom));
        else if (pick < 45) send_word(OP_CPU_RD, 16'($urandom), 8'($urandom));
        else if (pick < 60) send_word(OP_PPU_RD, 16'($urandom_range(0, 16'h2FFF)), 8'($urandom));
        else if (pick < 65) send_word(OP_PPU_WR, 16'($urandom_range(0, 16'h2FFF)), 8'($urandom));
        else if (pick < 90) send_word(OP_TICK, 16'($urandom), 8'($urandom));
        else if (pick < 94) send_word(OP_ACK, 16'($urandom), 8'($urandom));
        else send_word(3'($urandom), 16'($urandom), 8'($urandom));
    endtask

    initial begin
        int prg_set [4] = '{0, 1, 510, 5};
        int chr_set [4] = '{0, 2040, 1, 8};
        sb = new();
        sent = 0;
        no_idle = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_PRG_COUNT;
        cfg_data = 0;
        in_valid = 0;
        opcode = OP_TICK;
        address = 0;
        write_data = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: window edges, reset banks, counter wrap, tones
        send_word(OP_CPU_RD, 16'h0000, 8'h00);
        send_word(OP_CPU_RD, 16'h6000, 8'hFF);
        send_word(OP_CPU_RD, 16'hFFFF, 8'h00);
        send_word(OP_CPU_RD, 16'hC123, 8'h00);
        send_word(OP_PPU_RD, 16'h1FFF, 8'h00);
        send_word(OP_PPU_RD, 16'h2000, 8'h00);
        send_word(OP_PPU_WR, 16'h0400, 8'h00);
        send_word(OP_CPU_WR, 16'h7FFF, 8'hFF);
        mapper_write(CMD_PRG0, 8'hFF);
        send_word(OP_CPU_RD, 16'h6ABC, 8'h00);
        mapper_write(4'h3, 8'hFF);
        send_word(OP_PPU_RD, 16'h0FFF, 8'h00);
        mapper_write(CMD_MIRROR, 8'h03);
        mapper_write(CMD_CNT_LO, 8'h01);
        mapper_write(CMD_CNT_HI, 8'h00);
        mapper_write(CMD_IRQCTL, 8'h81);
        sound_write(4'd8, 8'h0F);
        sound_write(4'd9, 8'h08);
        sound_write(4'd2, 8'h00);
        repeat (4) send_word(OP_TICK, 16'h0000, 8'h00);
        send_word(OP_ACK, 16'hFFFF, 8'h00);
        send_word(3'd7, 16'h8000, 8'h55);

        // per bank-count setting: hold the sender until everything is back, write the counts, then send random words
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_PRG_COUNT, 11'(prg_set[ph]));
            write_reg(CFG_CHR_COUNT, 11'(chr_set[ph]));
            for (int n = 0; n < 320; n++) begin
                if (ph == 3 && n == 240) no_idle = 1;
                random_word();
            end
        end

        drain();
        $display("covered %0d words over 4 bank-count settings, %0d results checked",
                 sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d left over", sb.mismatches, sb.pending.size());
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #8000000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule
